FILE: rtl/strided_conv3x3_padded_top_macros.svh
// ----------------------------------------------------------------------------
// strided 3x3 convolution assertion macros
// Shared concurrent assertion forms for the checker of the convolution block.
// ----------------------------------------------------------------------------
`ifndef STRIDED_CONV3X3_PADDED_TOP_MACROS_SVH
`define STRIDED_CONV3X3_PADDED_TOP_MACROS_SVH

// clocked property, switched off while reset is high
`define SCONV3_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds across reset
`define SCONV3_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/sconv3_pkg.sv
// ----------------------------------------------------------------------------
// sconv3_pkg
// Types and fixed constants shared by the strided 3x3 convolution modules.
// ----------------------------------------------------------------------------
package sconv3_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int TAP_IDX_W  = 4;
   localparam int NUM_TAPS   = 9;
   localparam int KDIM       = 3;
   localparam int ROW_W      = 16;
   localparam int FW_W       = 8;
   localparam int PAD_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int PROD_W     = 2 * SAMPLE_W;
   localparam int CSUM_W     = PROD_W + 2;
   localparam int ACC_W      = CSUM_W + 2;
   localparam int FRAC_SHIFT = 14;
   localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);
   localparam int Q_W        = ACC_W - FRAC_SHIFT;
   localparam int SAT_BITS   = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_HEIGHT = 3'd0,
      CSR_FRAME_WIDTH  = 3'd1,
      CSR_PAD_TOP      = 3'd2,
      CSR_PAD_BOTTOM   = 3'd3,
      CSR_PAD_LEFT     = 3'd4,
      CSR_PAD_RIGHT    = 3'd5,
      CSR_BIAS_VALUE   = 3'd6,
      CSR_RELU_ENABLE  = 3'd7
   } csr_index_type;

   typedef enum logic {
      OP_SAMPLE   = 1'b0,
      OP_TAP_LOAD = 1'b1
   } op_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef sample_type [KDIM-1:0]      column_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [CSUM_W-1:0]   csum_type;
   typedef logic signed [ACC_W-1:0]    acc_type;
   typedef logic signed [Q_W-1:0]      q_type;

   typedef struct packed {
      op_type                 op;
      logic [TAP_IDX_W-1:0]   tap_index;
      sample_type             value;
   } req_data_type;

   typedef struct packed {
      sample_type out_sample;
      logic       last_of_row;
      logic       last_of_frame;
   } rsp_data_type;

   // the two buffered rows at one column
   typedef struct packed {
      sample_type older;
      sample_type newer;
   } line_pair_type;

   typedef struct packed {
      logic shift;
      logic load_op;
      logic load_mul;
      logic load_sum;
   } cell_ctl_type;

   typedef struct packed {
      logic last_of_row;
      logic last_of_frame;
   } meta_type;

endpackage

FILE: rtl/sconv3_cell.sv
// ----------------------------------------------------------------------------
// sconv3_cell
// One window column: holds a column of three samples, passes it to the next
// cell on every sample transfer, and forms the registered column sum.
// ----------------------------------------------------------------------------
module sconv3_cell import sconv3_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  column_type   col_in,
   input  column_type   tap_in,
   output column_type   col_out,
   output csum_type     sum_out
);

   column_type hold_ff, hold_in;
   sample_type opnd_ff [KDIM];
   sample_type opnd_in [KDIM];
   sample_type tap_ff  [KDIM];
   sample_type tap_in_q [KDIM];
   prod_type   prod_ff [KDIM];
   prod_type   prod_in [KDIM];
   csum_type   sum_ff, sum_in;

   always_comb begin
      hold_in = ctl.shift ? col_in : hold_ff;
      for (int k = 0; k < KDIM; k++) begin
         opnd_in[k]  = ctl.load_op ? col_in[k] : opnd_ff[k];
         tap_in_q[k] = ctl.load_op ? tap_in[k] : tap_ff[k];
         prod_in[k]  = ctl.load_mul ? prod_type'(opnd_ff[k]) * prod_type'(tap_ff[k])
                                    : prod_ff[k];
      end
      sum_in = ctl.load_sum ? csum_type'(prod_ff[0]) + csum_type'(prod_ff[1])
                              + csum_type'(prod_ff[2])
                            : sum_ff;
   end

   // window columns start out as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= '0;
      end else begin
         hold_ff <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      opnd_ff <= opnd_in;
      tap_ff  <= tap_in_q;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   assign col_out = hold_ff;
   assign sum_out = sum_ff;

endmodule

FILE: rtl/sconv3_line_buf.sv
// ----------------------------------------------------------------------------
// sconv3_line_buf
// Two-row line buffer, one word per column, with registered read and
// write-to-read forwarding when both hit the same column.
// ----------------------------------------------------------------------------
module sconv3_line_buf import sconv3_pkg::*; #(
   parameter  int DEPTH  = 128,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] wr_addr,
   input  line_pair_type     wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output line_pair_type     rd_data
);

   line_pair_type mem [DEPTH];
   line_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (we && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/strided_conv3x3_padded_top.sv
// ----------------------------------------------------------------------------
// strided_conv3x3_padded_top
// Streaming 3x3 stride-2 convolution of one plane with zero padding. The block
// takes one transfer per cycle unless req_stall is high, sample or tap load
// alike; a result passes through the five pipeline registers after the sample
// that completes its window, and stalls on the result side back up through
// them before the input stalls. The rate is set by the window chain of three
// column cells, which shifts once per sample, and by the line buffer, which is
// read every cycle and written per sample. It needs no clearing after reset.
// ----------------------------------------------------------------------------
module strided_conv3x3_padded_top import sconv3_pkg::*; #(
   parameter int MAX_WIDTH = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_data_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_data_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CA_W  = ((COL_W > FW_W) ? COL_W : FW_W) + 2;
   localparam int RA_W  = ROW_W + 2;
   localparam int NSTG  = 5;
   localparam q_type Q_MAX = q_type'((1 << (SAT_BITS - 1)) - 1);
   localparam q_type Q_MIN = -Q_MAX - q_type'(1);

   // configuration
   logic [ROW_W-1:0] frame_height_ff, frame_height_in;
   logic [FW_W-1:0]  frame_width_ff, frame_width_in;
   logic [PAD_W-1:0] pad_top_ff, pad_top_in;
   logic             pad_bottom_ff, pad_bottom_in;
   logic [PAD_W-1:0] pad_left_ff, pad_left_in;
   logic             pad_right_ff, pad_right_in;
   sample_type       bias_ff, bias_in;
   logic             relu_ff, relu_in;

   sample_type kernel_ff [NUM_TAPS];
   sample_type kernel_in [NUM_TAPS];

   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;

   // geometry
   logic [ROW_W-1:0] t_eff;
   logic [FW_W-1:0]  fw_nz;
   logic [CA_W-1:0]  f_eff;
   logic [PAD_W-1:0] pt_eff, pl_eff;
   logic [RA_W-1:0]  row_pad, to_cnt, row_sum, row_idx;
   logic [CA_W-1:0]  col_pad, fo_cnt, col_sum, col_idx;
   logic             row_last, col_last, row_hit, col_hit, in_range;
   logic             row_shift, col_shift;
   logic [KDIM-1:0]  row_ok, col_ok;
   logic             col_wrap, row_wrap;

   logic     accept, sample_accept, tap_we, hit;
   meta_type hit_meta;

   // pipeline
   logic [NSTG-1:0] stg_valid_ff, stg_valid_in, stg_en;
   meta_type        meta_ff [NSTG-1];
   meta_type        meta_in [NSTG-1];
   acc_type         total_ff, total_in;
   rsp_data_type    rsp_data_ff, rsp_data_in;
   acc_type         relu_val, rnd_val;
   q_type           q_val;

   line_pair_type lb_rd, lb_wr;
   column_type    new_col;
   column_type    chain [KDIM+1];
   column_type    tap_col [KDIM];
   sample_type    win_tap [KDIM][KDIM];
   csum_type      cell_sum [KDIM];
   cell_ctl_type  cell_ctl;

   // configuration writes
   always_comb begin
      frame_height_in = frame_height_ff;
      frame_width_in  = frame_width_ff;
      pad_top_in      = pad_top_ff;
      pad_bottom_in   = pad_bottom_ff;
      pad_left_in     = pad_left_ff;
      pad_right_in    = pad_right_ff;
      bias_in         = bias_ff;
      relu_in         = relu_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata[ROW_W-1:0];
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata[FW_W-1:0];
            CSR_PAD_TOP:      pad_top_in      = csr_wdata[PAD_W-1:0];
            CSR_PAD_BOTTOM:   pad_bottom_in   = csr_wdata[0];
            CSR_PAD_LEFT:     pad_left_in     = csr_wdata[PAD_W-1:0];
            CSR_PAD_RIGHT:    pad_right_in    = csr_wdata[0];
            CSR_BIAS_VALUE:   bias_in         = sample_type'(csr_wdata);
            CSR_RELU_ENABLE:  relu_in         = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // handshake and pipeline advance, collapsing bubbles
   always_comb begin
      stg_en[NSTG-1] = !stg_valid_ff[NSTG-1] || !rsp_stall;
      for (int k = NSTG - 2; k >= 0; k--) begin
         stg_en[k] = !stg_valid_ff[k] || stg_en[k+1];
      end
   end

   assign req_stall     = !stg_en[0];
   assign accept        = req_valid && stg_en[0];
   assign sample_accept = accept && (req_data.op == OP_SAMPLE);
   assign tap_we        = accept && (req_data.op == OP_TAP_LOAD)
                          && (req_data.tap_index < TAP_IDX_W'(NUM_TAPS));

   // effective geometry and output position lookup
   always_comb begin
      t_eff  = (frame_height_ff == '0) ? ROW_W'(1) : frame_height_ff;
      fw_nz  = (frame_width_ff == '0) ? FW_W'(1) : frame_width_ff;
      f_eff  = (CA_W'(fw_nz) > CA_W'(MAX_WIDTH)) ? CA_W'(MAX_WIDTH) : CA_W'(fw_nz);
      pt_eff = (pad_top_ff == 2'd3) ? 2'd2 : pad_top_ff;
      pl_eff = (pad_left_ff == 2'd3) ? 2'd2 : pad_left_ff;

      row_pad = RA_W'(t_eff) + RA_W'(pt_eff) + RA_W'(pad_bottom_ff);
      to_cnt  = (row_pad < RA_W'(3)) ? '0 : (row_pad - RA_W'(1)) >> 1;
      col_pad = f_eff + CA_W'(pl_eff) + CA_W'(pad_right_ff);
      fo_cnt  = (col_pad < CA_W'(3)) ? '0 : (col_pad - CA_W'(1)) >> 1;

      in_range = (row_ff < t_eff) && (CA_W'(col_ff) < f_eff);
      row_last = (RA_W'(row_ff) + RA_W'(1)) == RA_W'(t_eff);
      col_last = (CA_W'(col_ff) + CA_W'(1)) == f_eff;

      // odd padded index: window closes one past the last real sample
      row_sum   = RA_W'(row_ff) + RA_W'(pt_eff);
      row_shift = row_sum[0];
      row_idx   = row_shift ? (row_sum >> 1) : ((row_sum >> 1) - RA_W'(1));
      row_hit   = (row_shift ? row_last : (row_sum >= RA_W'(2))) && (row_idx < to_cnt);

      col_sum   = CA_W'(col_ff) + CA_W'(pl_eff);
      col_shift = col_sum[0];
      col_idx   = col_shift ? (col_sum >> 1) : ((col_sum >> 1) - CA_W'(1));
      col_hit   = (col_shift ? col_last : (col_sum >= CA_W'(2))) && (col_idx < fo_cnt);

      hit = sample_accept && in_range && row_hit && col_hit;
      hit_meta.last_of_row   = (col_idx == fo_cnt - CA_W'(1));
      hit_meta.last_of_frame = hit_meta.last_of_row && (row_idx == to_cnt - RA_W'(1));

      // window rows and columns that fall inside the plane
      row_ok[0] = !row_shift && (row_ff >= ROW_W'(2));
      row_ok[1] = (row_ff != '0);
      row_ok[2] = 1'b1;
      col_ok[0] = !col_shift && (col_ff >= COL_W'(2));
      col_ok[1] = (col_ff != '0);
      col_ok[2] = 1'b1;

      col_wrap = (CA_W'(col_ff) + CA_W'(1)) >= f_eff;
      row_wrap = (RA_W'(row_ff) + RA_W'(1)) >= RA_W'(t_eff);
   end

   // position counters
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (sample_accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      kernel_in = kernel_ff;
      if (tap_we) begin
         kernel_in[req_data.tap_index] = req_data.value;
      end
   end

   // tap per window slot, moved down or right by one when the window closes late
   for (genvar i = 0; i < KDIM; i++) begin : g_row
      for (genvar j = 0; j < KDIM; j++) begin : g_col
         localparam int IDX_00 = i * KDIM + j;
         localparam int IDX_01 = (j >= 1) ? i * KDIM + j - 1 : 0;
         localparam int IDX_10 = (i >= 1) ? (i - 1) * KDIM + j : 0;
         localparam int IDX_11 = (i >= 1 && j >= 1) ? (i - 1) * KDIM + j - 1 : 0;
         sample_type sel_tap;
         assign sel_tap = row_shift
                          ? (col_shift ? kernel_ff[IDX_11] : kernel_ff[IDX_10])
                          : (col_shift ? kernel_ff[IDX_01] : kernel_ff[IDX_00]);
         assign win_tap[j][i] = (row_ok[i] && col_ok[j]) ? sel_tap : '0;
      end
      assign tap_col[i] = {win_tap[i][2], win_tap[i][1], win_tap[i][0]};
   end

   sconv3_line_buf #(
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .we      (sample_accept),
      .wr_addr (col_ff),
      .wr_data (lb_wr),
      .rd_addr (col_in),
      .rd_data (lb_rd)
   );

   assign lb_wr.older = lb_rd.newer;
   assign lb_wr.newer = req_data.value;
   // rows above the plane enter the window as zero
   assign new_col     = {req_data.value,
                         (row_ff != '0) ? lb_rd.newer : sample_type'(0),
                         (row_ff >= ROW_W'(2)) ? lb_rd.older : sample_type'(0)};
   assign chain[0]    = new_col;

   assign cell_ctl.shift    = sample_accept;
   assign cell_ctl.load_op  = stg_en[0];
   assign cell_ctl.load_mul = stg_en[1];
   assign cell_ctl.load_sum = stg_en[2];

   // cell k works on window column KDIM-1-k, newest first
   for (genvar k = 0; k < KDIM; k++) begin : g_cell
      sconv3_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (cell_ctl),
         .col_in  (chain[k]),
         .tap_in  (tap_col[KDIM-1-k]),
         .col_out (chain[k+1]),
         .sum_out (cell_sum[k])
      );
   end

   // stage valid bits and side info
   always_comb begin
      stg_valid_in[0] = stg_en[0] ? hit : stg_valid_ff[0];
      for (int k = 1; k < NSTG; k++) begin
         stg_valid_in[k] = stg_en[k] ? stg_valid_ff[k-1] : stg_valid_ff[k];
      end
      meta_in[0] = stg_en[0] ? hit_meta : meta_ff[0];
      for (int k = 1; k < NSTG - 1; k++) begin
         meta_in[k] = stg_en[k] ? meta_ff[k-1] : meta_ff[k];
      end
   end

   // bias, relu, round half up and saturate
   always_comb begin
      total_in = stg_en[3]
                 ? acc_type'(cell_sum[0]) + acc_type'(cell_sum[1]) + acc_type'(cell_sum[2])
                   + (acc_type'(bias_ff) <<< FRAC_SHIFT)
                 : total_ff;
      relu_val = (relu_ff && (total_ff < 0)) ? '0 : total_ff;
      rnd_val  = relu_val + acc_type'(ROUND_HALF);
      q_val    = q_type'(rnd_val[ACC_W-1:FRAC_SHIFT]);
      rsp_data_in = rsp_data_ff;
      if (stg_en[4]) begin
         if (q_val > Q_MAX) begin
            rsp_data_in.out_sample = sample_type'(Q_MAX);
         end else if (q_val < Q_MIN) begin
            rsp_data_in.out_sample = sample_type'(Q_MIN);
         end else begin
            rsp_data_in.out_sample = sample_type'(q_val);
         end
         rsp_data_in.last_of_row   = meta_ff[NSTG-2].last_of_row;
         rsp_data_in.last_of_frame = meta_ff[NSTG-2].last_of_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_height_ff <= ROW_W'(64);
         frame_width_ff  <= FW_W'(80);
         pad_top_ff      <= 2'd2;
         pad_bottom_ff   <= 1'b1;
         pad_left_ff     <= 2'd2;
         pad_right_ff    <= 1'b1;
         bias_ff         <= '0;
         relu_ff         <= 1'b0;
         for (int k = 0; k < NUM_TAPS; k++) begin
            kernel_ff[k] <= '0;
         end
         row_ff          <= '0;
         col_ff          <= '0;
         stg_valid_ff    <= '0;
      end else begin
         frame_height_ff <= frame_height_in;
         frame_width_ff  <= frame_width_in;
         pad_top_ff      <= pad_top_in;
         pad_bottom_ff   <= pad_bottom_in;
         pad_left_ff     <= pad_left_in;
         pad_right_ff    <= pad_right_in;
         bias_ff         <= bias_in;
         relu_ff         <= relu_in;
         kernel_ff       <= kernel_in;
         row_ff          <= row_in;
         col_ff          <= col_in;
         stg_valid_ff    <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      meta_ff     <= meta_in;
      total_ff    <= total_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = stg_valid_ff[NSTG-1];
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/sconv3_chk.sv
// ----------------------------------------------------------------------------
// sconv3_chk
// Port-level checks of the strided 3x3 convolution, bound to the top level.
// ----------------------------------------------------------------------------
`include "strided_conv3x3_padded_top_macros.svh"

module sconv3_chk import sconv3_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_data_type rsp_data
);

   // a stalled result keeps its valid and payload
   `SCONV3_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "result changed while stalled")

   // the pipeline is cleared by reset
   `SCONV3_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid right after reset")

   // with the output register empty every stage can move, so the input is open
   `SCONV3_ASSERT(a_no_idle_stall, clock, reset, !rsp_valid |-> !req_stall, "input stalled with empty output")

   // the end of the plane is always also the end of an output row
   `SCONV3_ASSERT(a_frame_end_row, clock, reset, rsp_valid && rsp_data.last_of_frame |-> rsp_data.last_of_row, "frame end without row end")

endmodule

bind strided_conv3x3_padded_top sconv3_chk u_sconv3_chk (.*);

FILE: tb/sv/strided_conv3x3_padded_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_conv3x3_padded_top_test
// Self-checking bench for the strided 3x3 convolution with zero padding. A
// queue-fed driver and a monitor idle and stall at random. Every accepted
// sample goes through a local copy of the window, line buffer and fixed-point
// arithmetic, and each result transfer is checked in order against it. Plane
// sizes, pads, bias and ReLU change between planes and once in a while in the
// middle of one.
// ----------------------------------------------------------------------------
module strided_conv3x3_padded_top_test;
   import sconv3_pkg::*;

   localparam int LINE_DEPTH    = 128;
   localparam int SETTLE_CYCLES = 16;
   localparam int REPORT_LIMIT  = 10;
   localparam int ITEM_TARGET   = 1600;
   localparam int IDLE_PCT      = 19;

   typedef enum int {
      FILL_FULL,
      FILL_SMALL,
      FILL_EXTREME
   } fill_kind;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_data_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_data_type          rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow of the register file
   int         cfg_height     = 64;
   int         cfg_width      = 80;
   int         cfg_pad_top    = 2;
   int         cfg_pad_bottom = 1;
   int         cfg_pad_left   = 2;
   int         cfg_pad_right  = 1;
   sample_type cfg_bias       = '0;
   logic       cfg_relu       = 1'b0;

   // shadow of the datapath state
   sample_type taps [NUM_TAPS]         = '{default: '0};
   sample_type line_older [LINE_DEPTH] = '{default: '0};
   sample_type line_newer [LINE_DEPTH] = '{default: '0};
   sample_type win [6]                 = '{default: '0};
   int         row_pos = 0;
   int         col_pos = 0;

   req_data_type pending_items [$];
   rsp_data_type expected_outputs [$];
   rsp_data_type oldest;
   int items_issued   = 0;
   int items_taken    = 0;
   int stimulus_count = 0;
   int results_seen   = 0;
   int fault_count    = 0;
   int idle_pct       = IDLE_PCT;

   strided_conv3x3_padded_top #(
      .MAX_WIDTH(LINE_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int eff_height();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   function automatic int eff_width();
      if (cfg_width == 0) return 1;
      return (cfg_width > LINE_DEPTH) ? LINE_DEPTH : cfg_width;
   endfunction

   function automatic int out_span(input int len, input int lead, input int after);
      int padded;
      padded = len + lead + after;
      return (padded < KDIM) ? 0 : (padded - KDIM) / 2 + 1;
   endfunction

   // output index whose window closes at real position p, or -1;
   // last gets the window's final padded position
   function automatic int window_close(input int p, input int len, input int lead,
                                       input int count, output int last);
      int k;
      last = p;
      k = p + lead - 2;
      if (k >= 0 && k % 2 == 0 && k / 2 < count) return k / 2;
      if (p == len - 1) begin
         k = p + lead - 1;
         if (k >= 0 && k % 2 == 0 && k / 2 < count) begin
            last = p + 1;
            return k / 2;
         end
      end
      return -1;
   endfunction

   function automatic void conv_step(input req_data_type item);
      int t_len, f_len, pt, pl, t_out, f_out, r, c, ci, to, fo, rend, cend, row, col;
      sample_type g [3][3];
      longint acc, q, hi;
      rsp_data_type res;
      if (item.op == OP_TAP_LOAD) begin
         if (item.tap_index < NUM_TAPS) taps[item.tap_index] = item.value;
         return;
      end
      t_len = eff_height();
      f_len = eff_width();
      pt    = (cfg_pad_top > 2) ? 2 : cfg_pad_top;
      pl    = (cfg_pad_left > 2) ? 2 : cfg_pad_left;
      t_out = out_span(t_len, pt, cfg_pad_bottom);
      f_out = out_span(f_len, pl, cfg_pad_right);
      r     = row_pos;
      c     = col_pos;
      ci    = (c < LINE_DEPTH) ? c : 0;
      // g[i][j] holds row r-2+i, column c-2+j
      g[0][0] = win[0]; g[1][0] = win[1]; g[2][0] = win[2];
      g[0][1] = win[3]; g[1][1] = win[4]; g[2][1] = win[5];
      g[0][2] = line_older[ci]; g[1][2] = line_newer[ci]; g[2][2] = item.value;
      to = -1;
      fo = -1;
      rend = 0;
      cend = 0;
      if (r < t_len && c < f_len) to = window_close(r, t_len, pt, t_out, rend);
      if (to >= 0) fo = window_close(c, f_len, pl, f_out, cend);
      if (fo >= 0) begin
         acc = longint'(cfg_bias) * (longint'(1) << FRAC_SHIFT);
         for (int dt = 0; dt < KDIM; dt++) begin
            row = rend - 2 + dt;
            if (row >= 0 && row < t_len) begin
               for (int df = 0; df < KDIM; df++) begin
                  col = cend - 2 + df;
                  if (col >= 0 && col < f_len)
                     acc += longint'(taps[dt * KDIM + df]) * longint'(g[row - r + 2][col - c + 2]);
               end
            end
         end
         if (cfg_relu && acc < 0) acc = 0;
         q  = (acc + ROUND_HALF) >>> FRAC_SHIFT;
         hi = (longint'(1) << (SAMPLE_W - 1)) - 1;
         if (q > hi) q = hi;
         if (q < -hi - 1) q = -hi - 1;
         res.out_sample    = sample_type'(q);
         res.last_of_row   = (fo == f_out - 1);
         res.last_of_frame = (fo == f_out - 1) && (to == t_out - 1);
         expected_outputs.push_back(res);
      end
      line_older[ci] = g[1][2];
      line_newer[ci] = item.value;
      win[0] = g[0][1]; win[1] = g[1][1]; win[2] = g[2][1];
      win[3] = g[0][2]; win[4] = g[1][2]; win[5] = g[2][2];
      if (col_pos + 1 >= f_len) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= t_len) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endfunction

   // samples still needed to bring the raster position back to the origin
   function automatic int steps_to_origin();
      int r, c, n;
      r = row_pos;
      c = col_pos;
      n = 0;
      while (r != 0 || c != 0) begin
         if (c + 1 >= eff_width()) begin
            c = 0;
            r = (r + 1 >= eff_height()) ? 0 : r + 1;
         end else begin
            c = c + 1;
         end
         n++;
      end
      return n;
   endfunction

   function automatic sample_type rand_value(input fill_kind fill);
      case (fill)
         FILL_SMALL: return sample_type'(int'($urandom_range(0, 8191)) - 4096);
         FILL_EXTREME: begin
            case ($urandom_range(0, 3))
               0:       return 16'sh7FFF;
               1:       return 16'sh8000;
               2:       return '0;
               default: return sample_type'($urandom);
            endcase
         end
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic void push_item(input op_type op, input int tap, input sample_type value);
      req_data_type item;
      item.op        = op;
      item.tap_index = tap[TAP_IDX_W-1:0];
      item.value     = value;
      pending_items.push_back(item);
      items_issued++;
      if (op == OP_SAMPLE || tap < NUM_TAPS) stimulus_count++;
   endfunction

   // raster samples with the odd tap load mixed in, some to unused slots
   function automatic void send_samples(input int count, input fill_kind fill,
                                        input int noise_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < noise_pct)
            push_item(OP_TAP_LOAD, $urandom_range(0, 15), rand_value(fill));
         push_item(OP_SAMPLE, $urandom_range(0, 15), rand_value(fill));
      end
   endfunction

   function automatic void load_taps(input fill_kind fill);
      for (int i = 0; i < NUM_TAPS; i++) push_item(OP_TAP_LOAD, i, rand_value(fill));
   endfunction

   task automatic csr_write(input csr_index_type idx, input int data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_FRAME_HEIGHT: cfg_height     = data & 'hFFFF;
         CSR_FRAME_WIDTH:  cfg_width      = data & 'hFF;
         CSR_PAD_TOP:      cfg_pad_top    = data & 3;
         CSR_PAD_BOTTOM:   cfg_pad_bottom = data & 1;
         CSR_PAD_LEFT:     cfg_pad_left   = data & 3;
         CSR_PAD_RIGHT:    cfg_pad_right  = data & 1;
         CSR_BIAS_VALUE:   cfg_bias       = data[SAMPLE_W-1:0];
         CSR_RELU_ENABLE:  cfg_relu       = data[0];
         default: ;
      endcase
   endtask

   task automatic set_geometry(input int height, input int width, input int top,
                               input int bottom, input int left, input int right,
                               input int bias, input int relu);
      csr_write(CSR_FRAME_HEIGHT, height);
      csr_write(CSR_FRAME_WIDTH, width);
      csr_write(CSR_PAD_TOP, top);
      csr_write(CSR_PAD_BOTTOM, bottom);
      csr_write(CSR_PAD_LEFT, left);
      csr_write(CSR_PAD_RIGHT, right);
      csr_write(CSR_BIAS_VALUE, bias);
      csr_write(CSR_RELU_ENABLE, relu);
   endtask

   // every item taken, every result back, then room for the pipeline to empty
   task automatic wait_idle();
      while (items_taken != items_issued || expected_outputs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            conv_step(req_data);
            items_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_outputs.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("result %0d unexpected: sample %0d row_end %b frame_end %b",
                           results_seen, rsp_data.out_sample, rsp_data.last_of_row,
                           rsp_data.last_of_frame);
            end else begin
               oldest = expected_outputs.pop_front();
               if (rsp_data.out_sample !== oldest.out_sample ||
                   rsp_data.last_of_row !== oldest.last_of_row ||
                   rsp_data.last_of_frame !== oldest.last_of_frame) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT)
                     $display("result %0d mismatch: expected %0d/%b/%b got %0d/%b/%b",
                              results_seen, oldest.out_sample, oldest.last_of_row,
                              oldest.last_of_frame, rsp_data.out_sample,
                              rsp_data.last_of_row, rsp_data.last_of_frame);
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < idle_pct);
      end
   end

   initial begin
      int height, width, frames;
      fill_kind fill;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // full-scale taps and samples drive both saturation limits
      set_geometry(3, 3, 0, 0, 0, 0, 0, 0);
      for (int i = 0; i < NUM_TAPS; i++) push_item(OP_TAP_LOAD, i, 16'sh7FFF);
      push_item(OP_TAP_LOAD, 9, 16'sh1234);
      push_item(OP_TAP_LOAD, 15, 16'sh8000);
      for (int i = 0; i < 9; i++) push_item(OP_SAMPLE, 0, 16'sh7FFF);
      for (int i = 0; i < 9; i++) push_item(OP_SAMPLE, 15, 16'sh8000);
      wait_idle();
      // zero sizes act as one, pads of three act as two
      set_geometry(0, 0, 3, 1, 3, 1, -32768, 1);
      push_item(OP_SAMPLE, 5, 16'sh7FFF);
      push_item(OP_SAMPLE, 10, 16'sh8000);
      wait_idle();
      // plane too small for any window
      set_geometry(1, 2, 0, 0, 0, 0, 32767, 0);
      push_item(OP_SAMPLE, 0, 16'sh7FFF);
      push_item(OP_SAMPLE, 0, 16'sh7FFF);
      wait_idle();

      while (stimulus_count < ITEM_TARGET) begin
         idle_pct = (stimulus_count > 600 && stimulus_count < 1000) ? 0 : IDLE_PCT;
         fill = fill_kind'($urandom_range(0, 2));
         case ($urandom_range(0, 23))
            0:       width = 0;
            1:       width = 1;
            2:       width = 2;
            3:       width = LINE_DEPTH;
            4:       width = 255;
            5:       width = $urandom_range(LINE_DEPTH + 1, 254);
            default: width = $urandom_range(3, 12);
         endcase
         if (width >= LINE_DEPTH) begin
            height = $urandom_range(0, 2);
         end else begin
            case ($urandom_range(0, 9))
               0:       height = 0;
               1:       height = 1;
               2:       height = 2;
               default: height = $urandom_range(1, 8);
            endcase
         end
         set_geometry(height, width, $urandom_range(0, 3), $urandom_range(0, 1),
                      $urandom_range(0, 3), $urandom_range(0, 1),
                      rand_value(fill_kind'($urandom_range(0, 2))), $urandom_range(0, 1));
         if ($urandom_range(0, 1) == 0) load_taps(fill_kind'($urandom_range(0, 2)));
         if (width < LINE_DEPTH && $urandom_range(0, 5) == 0) begin
            // stop partway, retune while idle, then finish under the new sizes;
            // the width never grows here so no unwritten line entry is used
            if ($urandom_range(0, 1) == 0) begin
               wait_idle();
               csr_write(CSR_FRAME_HEIGHT, 'hFFFF);
            end
            send_samples($urandom_range(1, 4 * eff_width()), fill, 5);
            wait_idle();
            set_geometry($urandom_range(0, 6), $urandom_range(0, width),
                         $urandom_range(0, 3), $urandom_range(0, 1),
                         $urandom_range(0, 3), $urandom_range(0, 1),
                         rand_value(fill), $urandom_range(0, 1));
            send_samples(steps_to_origin(), fill, 5);
         end else begin
            frames = (width >= LINE_DEPTH) ? 1 : $urandom_range(1, 3);
            send_samples(frames * eff_height() * eff_width(), fill, 4);
         end
         wait_idle();
      end

      if (fault_count == 0 && expected_outputs.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #1ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
